// File: hdl/tdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_pkg
// shared types and constants of the tile deduplication compressor
// ----------------------------------------------------------------------------
package tdc_pkg;

    localparam int PIXEL_BITS = 15;
    localparam int CODE_BITS  = 16;
    localparam int USED_BITS  = 6;
    localparam int ADDR_MAX   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_W_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_H_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_EXIST = 2'd2;

    typedef struct packed {
        logic                  mode;
        logic [PIXEL_BITS-1:0] pixel_value;
        logic                  in_image;
        logic                  last_in_tile;
    } pixel_t;

    typedef struct packed {
        logic signed [CODE_BITS-1:0] tile_code;
        logic                        status;
        logic [USED_BITS-1:0]        tiles_used;
    } result_t;

    // pixel access broadcast to every cell in the accept cycle
    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX-1:0]   addr;
        logic [PIXEL_BITS-1:0] data;
    } tdc_acc_t;

    // compare step, registered, in the cycle after the access
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  in_image;
        logic [ADDR_MAX-1:0]   addr;
        logic [PIXEL_BITS-1:0] value;
    } tdc_cmp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_SEARCH
    } tdc_state_t;

endpackage

`default_nettype wire

// File: hdl/tile_dedup_compressor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_dedup_compressor
// codes tiles as a uniform value or as the index of a matching stored tile
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while busy is low; a pixel goes to every
// stored-tile cell at once. After the last pixel of a tile the block is busy
// in a settle state, and when the tile is not uniform and matching is on, also
// in a search state, where the match flags shift down the cell chain to the
// head one cell per cycle until the head flags a match or every stored tile
// (zero tile included) has been checked.
// The result is shown for one cycle on done and must be taken then. A restart
// is taken like a pixel and needs no clearing pass.
module tile_dedup_compressor
    import tdc_pkg::*;
#(
    parameter int MAX_TILES          = 64,
    parameter int MAX_TILE_SIDE_LOG2 = 3
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire pixel_t                pixel,
    output logic                       done,
    output result_t                    result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = 2 * MAX_TILE_SIDE_LOG2;
    localparam int TC_W   = $clog2(MAX_TILES + 1);

    tdc_state_t            state_reg, state_next;
    logic [1:0]            tile_w_reg, tile_h_reg;
    logic                  match_reg;
    logic [SLOT_W-1:0]     pos_reg, pos_next;
    logic                  past_end_reg, past_end_next;
    logic [PIXEL_BITS-1:0] first_reg, first_next;
    logic                  uni_reg, uni_next;
    logic [TC_W-1:0]       count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [TC_W-1:0]       idx_reg, idx_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;
    tdc_cmp_t              cmp_reg, cmp_next;
    tdc_acc_t              acc;
    logic                  shift;
    logic                  accept;
    logic                  proc;
    logic [2:0]            side_w, side_h;
    logic [3:0]            shamt;
    logic [SLOT_W:0]       p_plus;
    logic [PIXEL_BITS-1:0] pix_data;
    logic [MAX_TILES-1:0]  flags;
    logic                  fin_uni, fin_new, fin_found;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign proc   = accept && !pixel.mode && !past_end_reg;

    assign side_w = ({1'b0, tile_w_reg} > 3'(MAX_TILE_SIDE_LOG2)) ?
                    3'(MAX_TILE_SIDE_LOG2) : {1'b0, tile_w_reg};
    assign side_h = ({1'b0, tile_h_reg} > 3'(MAX_TILE_SIDE_LOG2)) ?
                    3'(MAX_TILE_SIDE_LOG2) : {1'b0, tile_h_reg};
    assign shamt  = {1'b0, side_w} + {1'b0, side_h};
    assign p_plus = {1'b0, pos_reg} + (SLOT_W+1)'(1);

    assign pix_data = pixel.in_image ? pixel.pixel_value : '0;

    assign acc.en   = proc;
    assign acc.addr = ADDR_MAX'(pos_reg);
    assign acc.data = pix_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_w_reg <= 2'd3;
            tile_h_reg <= 2'd3;
            match_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TILE_W_LOG2: tile_w_reg <= cfg_data;
                CFG_TILE_H_LOG2: tile_h_reg <= cfg_data;
                CFG_MATCH_EXIST: match_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_TILES; k++)
        begin : g_cell
            logic flag_in;
            if (k == MAX_TILES - 1)
            begin : g_tail
                assign flag_in = 1'b0;
            end
            else
            begin : g_link
                assign flag_in = flags[k+1];
            end
            tdc_cell #(
                .SLOT_W (SLOT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .acc     (acc),
                .cmp     (cmp_reg),
                .shift   (shift),
                .wr_sel  (count_reg == TC_W'(k)),
                .cmp_sel (TC_W'(k) < count_reg),
                .flag_in (flag_in),
                .flag    (flags[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        past_end_next = past_end_reg;
        first_next    = first_reg;
        uni_next      = uni_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        shift         = 1'b0;
        fin_uni       = 1'b0;
        fin_new       = 1'b0;
        fin_found     = 1'b0;

        cmp_next.valid    = proc;
        cmp_next.first    = (pos_reg == '0);
        cmp_next.in_image = pixel.in_image;
        cmp_next.addr     = ADDR_MAX'(pos_reg);
        cmp_next.value    = pixel.pixel_value;

        if (accept && pixel.mode)
        begin
            count_next    = TC_W'(1);
            ovf_next      = 1'b0;
            pos_next      = '0;
            past_end_next = 1'b0;
        end
        else if (accept)
        begin
            if (!past_end_reg)
            begin
                if (pos_reg == '0)
                begin
                    first_next = pix_data;
                    uni_next   = 1'b1;
                end
                else if (pixel.in_image && pixel.pixel_value != first_reg)
                begin
                    uni_next = 1'b0;
                end
                if ((p_plus >> shamt) != '0)
                begin
                    past_end_next = 1'b1;
                end
                else
                begin
                    pos_next = p_plus[SLOT_W-1:0];
                end
            end
            if (pixel.last_in_tile)
            begin
                pos_next      = '0;
                past_end_next = 1'b0;
                state_next    = ST_SETTLE;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SETTLE:
            begin
                if (uni_reg)
                begin
                    fin_uni = 1'b1;
                end
                else if (match_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_SEARCH;
                end
                else
                begin
                    fin_new = 1'b1;
                end
            end
            ST_SEARCH:
            begin
                if (idx_reg == count_reg)
                begin
                    fin_new = 1'b1;
                end
                else if (flags[0])
                begin
                    fin_found = 1'b1;
                end
                else
                begin
                    shift    = 1'b1;
                    idx_next = idx_reg + TC_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin_uni || fin_new || fin_found)
        begin
            state_next = ST_IDLE;
            done_next  = 1'b1;
            if (fin_uni)
            begin
                result_next.tile_code = CODE_BITS'(first_reg);
            end
            else if (fin_found)
            begin
                result_next.tile_code = CODE_BITS'(0) - CODE_BITS'(idx_reg);
            end
            else if (count_reg < TC_W'(MAX_TILES))
            begin
                result_next.tile_code = CODE_BITS'(0) - CODE_BITS'(count_reg);
                count_next            = count_reg + TC_W'(1);
            end
            else
            begin
                result_next.tile_code = '0;
                ovf_next              = 1'b1;
            end
            result_next.status     = ovf_next;
            result_next.tiles_used = USED_BITS'(count_next - TC_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            past_end_reg <= 1'b0;
            uni_reg      <= 1'b1;
            count_reg    <= TC_W'(1);
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            done_reg     <= 1'b0;
            cmp_reg      <= '0;
            first_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            past_end_reg <= past_end_next;
            uni_reg      <= uni_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            idx_reg      <= idx_next;
            done_reg     <= done_next;
            cmp_reg      <= cmp_next;
            first_reg    <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without end-of-tile work");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= TC_W'(1) && count_reg <= TC_W'(MAX_TILES))
        else $error("tile count out of range");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> idx_reg <= count_reg)
        else $error("search ran past stored tiles");

    a_no_compare_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> !cmp_reg.valid)
        else $error("compare overlaps search");
`endif

endmodule

`default_nettype wire

// File: hdl/tdc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_cell
// one stored tile slot: pixel memory, fill count and match flag
// ----------------------------------------------------------------------------
module tdc_cell
    import tdc_pkg::*;
#(
    parameter int SLOT_W = 6
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tdc_acc_t acc,
    input  wire tdc_cmp_t cmp,
    input  wire logic     shift,
    input  wire logic     wr_sel,
    input  wire logic     cmp_sel,
    input  wire logic     flag_in,
    output logic          flag
);

    localparam int SLOT = 1 << SLOT_W;

    logic [PIXEL_BITS-1:0] mem [SLOT];
    logic [PIXEL_BITS-1:0] rdata_reg;
    logic [SLOT_W:0]       fill_reg;
    logic [SLOT_W:0]       fill_next;
    logic                  flag_reg;
    logic                  flag_next;
    logic [SLOT_W-1:0]     acc_addr;
    logic [SLOT_W-1:0]     cmp_addr;
    logic                  hit;
    logic                  mism;

    assign acc_addr = acc.addr[SLOT_W-1:0];
    assign cmp_addr = cmp.addr[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (acc.en && wr_sel)
        begin
            mem[acc_addr] <= acc.data;
        end
        if (acc.en)
        begin
            rdata_reg <= mem[acc_addr];
        end
    end

    // positions past the fill count read as zero
    always_comb
    begin
        fill_next = fill_reg;
        if (acc.en && wr_sel)
        begin
            fill_next = {1'b0, acc_addr} + (SLOT_W+1)'(1);
        end
        if ({1'b0, cmp_addr} < fill_reg)
        begin
            hit = (rdata_reg == cmp.value);
        end
        else
        begin
            hit = (cmp.value == '0);
        end
        mism = cmp.in_image && cmp_sel && !hit;
        flag_next = flag_reg;
        if (shift)
        begin
            flag_next = flag_in;
        end
        else if (cmp.valid)
        begin
            flag_next = (cmp.first | flag_reg) & !mism;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            flag_reg <= 1'b1;
        end
        else
        begin
            fill_reg <= fill_next;
            flag_reg <= flag_next;
        end
    end

    assign flag = flag_reg;

endmodule

`default_nettype wire

// File: bench/tb_tile_dedup_compressor.sv
// ----------------------------------------------------------------------------
// tb_tile_dedup_compressor
// self-checking bench for the tile deduplication compressor
// ----------------------------------------------------------------------------
// A queue of pixel items, register writes and drain points feeds a clocked
// driver. A clocked monitor predicts the code of every finished tile from
// its own model of the tile table and checks each strobed result against it.
// Stimulus covers uniform, duplicate, padded, short, long and random tiles,
// restarts, several tile sizes and a table overflow with matching off.
module tb_tile_dedup_compressor;
    import tdc_pkg::*;

    localparam int NTILES    = 64;
    localparam int SLOT      = 64;
    localparam int SETTLE    = 80;
    localparam int IDLE_MAX  = 1000;

    typedef enum int {OP_PIXEL, OP_CFG, OP_DRAIN} op_kind_t;

    typedef struct {
        op_kind_t               kind;
        pixel_t                 px;
        int                     gap;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
    } op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    pixel_t pixel = '0;
    logic done;
    result_t result;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tile_dedup_compressor u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .pixel(pixel),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    op_t      pending_ops[$];
    result_t  expected_codes[$];
    int       errors = 0;
    int       n_uniform = 0, n_matched = 0, n_stored = 0, n_overflow = 0;
    int       n_pixels = 0, n_restarts = 0;
    bit       stim_done = 0;

    // tile table model
    logic [PIXEL_BITS-1:0] tbl[NTILES*SLOT];
    int                    tbl_count;
    bit [NTILES-1:0]       still_match;
    logic [PIXEL_BITS-1:0] ref_px;
    bit                    all_same;
    int                    pos;
    bit                    overrun;
    bit                    overflowed;
    int                    m_w, m_h;
    bit                    m_match;

    initial begin
        forever #1 clk = ~clk;
    end

    task automatic begin_tile();
        pos = 0;
        overrun = 0;
        ref_px = '0;
        all_same = 1;
        still_match = '1;
    endtask

    task automatic clear_table();
        foreach (tbl[i]) tbl[i] = '0;
        tbl_count = 1;
        overflowed = 0;
        begin_tile();
    endtask

    task automatic predict_tile(pixel_t px);
        int p;
        int sz;
        int k;
        bit found;
        logic [PIXEL_BITS-1:0] v;
        result_t r;
        if (px.mode) begin
            clear_table();
            n_restarts++;
            return;
        end
        n_pixels++;
        v = px.in_image ? px.pixel_value : '0;
        sz = 1 << (m_w + m_h);
        if (!overrun) begin
            p = pos % SLOT;
            if (p == 0) begin
                begin_tile();
                if (tbl_count < NTILES)
                    for (int i = 0; i < SLOT; i++) tbl[tbl_count*SLOT + i] = '0;
                ref_px = v;
            end
            if (tbl_count < NTILES) tbl[tbl_count*SLOT + p] = v;
            if (px.in_image) begin
                if (v != ref_px) all_same = 0;
                for (k = 0; k < tbl_count && k < NTILES; k++)
                    if (tbl[k*SLOT + p] != v) still_match[k] = 0;
            end
            if (p + 1 >= sz) overrun = 1;
            else pos = p + 1;
        end
        if (!px.last_in_tile) return;
        found = 0;
        if (all_same) begin
            r.tile_code = {1'b0, ref_px};
            n_uniform++;
        end else begin
            r.tile_code = '0;
            if (m_match)
                for (k = 0; k < tbl_count && k < NTILES && !found; k++)
                    if (still_match[k]) begin
                        r.tile_code = CODE_BITS'(-k);
                        found = 1;
                        n_matched++;
                    end
            if (!found) begin
                if (tbl_count < NTILES) begin
                    r.tile_code = CODE_BITS'(-tbl_count);
                    tbl_count++;
                    n_stored++;
                end else begin
                    overflowed = 1;
                    n_overflow++;
                end
            end
        end
        r.status = overflowed;
        r.tiles_used = USED_BITS'(tbl_count - 1);
        expected_codes.push_back(r);
        begin_tile();
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    int wait_cnt = 0;
    int drain_cnt = 0;
    always @(posedge clk) begin
        bit go;
        bit we;
        go = start && busy;
        we = 0;
        if (!rst_n) go = 0;
        else if (!go && pending_ops.size() != 0) begin
            case (pending_ops[0].kind)
                OP_PIXEL:
                    if (wait_cnt < pending_ops[0].gap) wait_cnt++;
                    else begin
                        pixel <= pending_ops[0].px;
                        go = 1;
                        wait_cnt = 0;
                        void'(pending_ops.pop_front());
                    end
                OP_CFG:
                    begin
                        we = 1;
                        cfg_index <= pending_ops[0].idx;
                        cfg_data <= pending_ops[0].data;
                        void'(pending_ops.pop_front());
                    end
                default:
                    begin
                        if (expected_codes.size() != 0 || start) drain_cnt = 0;
                        else drain_cnt++;
                        if (drain_cnt >= SETTLE) begin
                            drain_cnt = 0;
                            void'(pending_ops.pop_front());
                        end
                    end
            endcase
        end
        start <= go;
        cfg_we <= we;
    end

    // monitor, predictor and watchdog
    int idle_cycles = 0;
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (start && !busy) predict_tile(pixel);
            if (cfg_we)
                case (cfg_index)
                    CFG_TILE_W_LOG2: m_w = int'(cfg_data);
                    CFG_TILE_H_LOG2: m_h = int'(cfg_data);
                    CFG_MATCH_EXIST: m_match = cfg_data[0];
                    default: ;
                endcase
            if (done) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("unexpected tile_code", int'(result.tile_code), 0);
                end else begin
                    want = expected_codes.pop_front();
                    if (result.tile_code !== want.tile_code)
                        report_mismatch("tile_code", int'(result.tile_code),
                                        int'(want.tile_code));
                    if (result.status !== want.status)
                        report_mismatch("status", int'(result.status), int'(want.status));
                    if (result.tiles_used !== want.tiles_used)
                        report_mismatch("tiles_used", int'(result.tiles_used),
                                        int'(want.tiles_used));
                end
            end
            if ((start && !busy) || done || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("watchdog expired with %0d results outstanding",
                         expected_codes.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // stimulus
    int gen_w = 3, gen_h = 3;
    int gap_max = 0;
    logic [PIXEL_BITS-1:0] lib[4][SLOT];

    task automatic push_px(bit md, logic [PIXEL_BITS-1:0] v, bit inimg, bit last);
        op_t o;
        o.kind = OP_PIXEL;
        o.px.mode = md;
        o.px.pixel_value = v;
        o.px.in_image = inimg;
        o.px.last_in_tile = last;
        o.gap = $urandom_range(0, gap_max);
        o.idx = '0;
        o.data = '0;
        pending_ops.push_back(o);
    endtask

    task automatic push_drain();
        op_t o;
        o.kind = OP_DRAIN;
        o.px = '0;
        o.gap = 0;
        o.idx = '0;
        o.data = '0;
        pending_ops.push_back(o);
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
        op_t o;
        o.kind = OP_CFG;
        o.px = '0;
        o.gap = 0;
        o.idx = i;
        o.data = d;
        pending_ops.push_back(o);
        if (i == CFG_TILE_W_LOG2) gen_w = int'(d);
        if (i == CFG_TILE_H_LOG2) gen_h = int'(d);
    endtask

    task automatic set_shape(int w, int h, int m);
        push_drain();
        push_cfg(CFG_TILE_W_LOG2, CFG_DATA_W'(w));
        push_cfg(CFG_TILE_H_LOG2, CFG_DATA_W'(h));
        push_cfg(CFG_MATCH_EXIST, CFG_DATA_W'(m));
    endtask

    task automatic gen_tile();
        int sz;
        int n;
        int flavor;
        int pick;
        bit padded;
        logic [PIXEL_BITS-1:0] v;
        logic [PIXEL_BITS-1:0] u;
        sz = 1 << (gen_w + gen_h);
        n = sz;
        case ($urandom_range(0, 9))
            0: n = $urandom_range(1, sz);
            1: n = sz + $urandom_range(1, 3);
            default: ;
        endcase
        flavor = $urandom_range(0, 5);
        pick = $urandom_range(0, 3);
        u = PIXEL_BITS'($urandom_range(0, 32767));
        padded = ($urandom_range(0, 3) == 0);
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
        for (int p = 0; p < n; p++) begin
            case (flavor)
                0: v = '0;
                1: v = u;
                2, 3: v = lib[pick][p % SLOT];
                4: v = PIXEL_BITS'($urandom_range(0, 1));
                default: v = PIXEL_BITS'($urandom_range(0, 32767));
            endcase
            push_px(0, v, !(padded && $urandom_range(0, 2) == 0), p == n - 1);
        end
        if ($urandom_range(0, 40) == 0)
            push_px(1, PIXEL_BITS'($urandom_range(0, 32767)),
                    ($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1));
        if ($urandom_range(0, 25) == 0) push_drain();
    endtask

    initial begin
        m_w = 3;
        m_h = 3;
        m_match = 1;
        clear_table();
        foreach (lib[j, p]) lib[j][p] = (j == 0) ? PIXEL_BITS'($urandom_range(0, 32767))
                                                 : PIXEL_BITS'($urandom_range(0, 3));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: 2x2 tiles
        set_shape(1, 1, 1);
        for (int p = 0; p < 4; p++) push_px(0, 0, 1, p == 3);
        for (int p = 0; p < 4; p++) push_px(0, 15'h7fff, 1, p == 3);
        push_px(0, 5, 0, 0);
        for (int p = 1; p < 4; p++) push_px(0, 7, 1, p == 3);
        for (int p = 0; p < 4; p++) push_px(0, PIXEL_BITS'(p + 1), 1, p == 3);
        for (int p = 0; p < 4; p++) push_px(0, PIXEL_BITS'(p + 1), 1, p == 3);
        for (int p = 0; p < 4; p++)
            push_px(0, PIXEL_BITS'((p == 2) ? 99 : p + 1), p != 2, p == 3);
        push_px(0, 1, 1, 0);
        push_px(0, 2, 1, 1);
        for (int p = 0; p < 6; p++) push_px(0, PIXEL_BITS'(p * 3), 1, p == 5);
        push_px(0, 9, 1, 0);
        push_px(0, 8, 1, 0);
        push_px(1, 15'h7fff, 1, 1);
        for (int p = 0; p < 4; p++) push_px(0, PIXEL_BITS'(p + 1), 1, p == 3);

        // random over several shapes
        set_shape(0, 0, 1);
        repeat (30) gen_tile();
        set_shape(3, 3, 1);
        repeat (2) gen_tile();
        set_shape(2, 1, 0);
        repeat (12) gen_tile();
        set_shape(1, 2, 1);
        repeat (12) gen_tile();
        // fill the table past its end with matching off
        set_shape(1, 0, 0);
        push_px(1, 0, 0, 0);
        for (int t = 0; t < 70; t++) begin
            gap_max = (t % 3 == 0) ? 14 : 0;
            push_px(0, PIXEL_BITS'(t + 1), 1, 0);
            push_px(0, PIXEL_BITS'(15'h4000 | t), 1, 1);
        end
        set_shape(1, 0, 1);
        repeat (15) gen_tile();
        push_px(1, 0, 1, 1);
        set_shape(3, 2, 1);
        repeat (2) gen_tile();
        push_drain();
        stim_done = 1;
    end

    initial begin
        wait (rst_n);
        wait (stim_done && pending_ops.size() == 0);
        @(posedge clk);
        if (expected_codes.size() != 0)
            report_mismatch("results outstanding", expected_codes.size(), 0);
        $display("pixels %0d restarts %0d, tiles: uniform %0d matched %0d stored %0d",
                 n_pixels, n_restarts, n_uniform, n_matched, n_stored);
        $display("tiles refused on a full table %0d, mismatches %0d", n_overflow, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
